// ===== rtl/core/ppm_frame_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ppm frame decoder assertion macros
// concurrent assertion shorthands shared by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_UNIT_ASSERT_SVH
`define PPM_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define PPMFD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppm frame decoder: assertion failed");

// next-cycle implication
`define PPMFD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppm frame decoder: assertion failed");

`endif

// ===== rtl/core/ppmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm frame decoder package
// shared types, register map and operation codes
// ----------------------------------------------------------------------------
package ppmfd_pkg;

	localparam int WIDTH_W = 16;
	localparam int COUNT_W = 4;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [WIDTH_W-1:0] SYNC_THRESHOLD_RESET = 16'd8000;
	localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET  = 4'd7;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_EDGE = 2'd1,
		OP_READ = 2'd2
	} op_t;

	// register select is address bit 2
	typedef enum logic {
		REG_SYNC_THRESHOLD = 1'b0,
		REG_CHANNEL_COUNT  = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] sync_threshold;
		logic [COUNT_W-1:0] channel_count;
	} cfg_t;

endpackage

// ===== rtl/core/ppmfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppm frame decoder configuration registers
// apb-style register file holding sync threshold and channel count
// ----------------------------------------------------------------------------
module ppmfd_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppmfd_pkg::ADDR_W-1:0] paddr,
	input  logic [ppmfd_pkg::DATA_W-1:0] pwdata,
	output logic [ppmfd_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output ppmfd_pkg::cfg_t              cfg
);
	import ppmfd_pkg::*;

	logic [WIDTH_W-1:0] sync_threshold_q;
	logic [COUNT_W-1:0] channel_count_q;
	logic               wr_en;
	reg_sel_t           sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign sel    = reg_sel_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_threshold_q <= SYNC_THRESHOLD_RESET;
			channel_count_q  <= CHANNEL_COUNT_RESET;
		end else if (wr_en) begin
			case (sel)
				REG_SYNC_THRESHOLD: sync_threshold_q <= pwdata[WIDTH_W-1:0];
				REG_CHANNEL_COUNT:  channel_count_q  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_SYNC_THRESHOLD: prdata = DATA_W'(sync_threshold_q);
			REG_CHANNEL_COUNT:  prdata = DATA_W'(channel_count_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.sync_threshold = sync_threshold_q;
	assign cfg.channel_count  = channel_count_q;

endmodule

// ===== rtl/core/ppm_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ppm frame decoder unit
// decodes an rc pulse-position stream into per-channel pulse widths
// ----------------------------------------------------------------------------
// Each input beat is a tick, a rising edge or a slot read. A beat is latched
// into an input register and resolved from there against the tick counter,
// the slot index and the slot store, with the result landing in an output
// register; one beat is taken every cycle unless the output register stalls
// the input side. The output register stalls the input side only when it
// holds an untaken result and the beat in the input register produces one too.
// Edges report the slot written, the interval and whether it exceeded the sync
// threshold; reads return a stored slot, or zero for slots beyond the store.
`include "ppm_frame_decoder_unit_assert.svh"

module ppm_frame_decoder_unit #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppmfd_pkg::ADDR_W-1:0] paddr,
	input  logic [ppmfd_pkg::DATA_W-1:0] pwdata,
	output logic [ppmfd_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [2:0]                   read_slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   slot,
	output logic [15:0]                  width,
	output logic                         sync_gap
);
	import ppmfd_pkg::*;

	localparam int         IDX_W   = $clog2(MAX_CHANNELS);
	localparam logic [4:0] MAX_LEN = 5'(MAX_CHANNELS);

	cfg_t cfg;

	logic               v_s1;
	logic [1:0]         op_s1;
	logic [2:0]         rs_s1;

	logic [WIDTH_W-1:0] tick_q;
	logic [2:0]         slot_idx_q;
	logic [WIDTH_W-1:0] widths_q [MAX_CHANNELS];

	logic               out_valid_q;
	logic [2:0]         slot_q;
	logic [WIDTH_W-1:0] width_q;
	logic               gap_q;

	logic               is_tick, is_edge, is_read, has_res, advance, fire;
	logic               gap, wrap, wr_ok, rd_ok;
	logic [4:0]         frame_len, cnt_ext, idx_next, wr_ext, rd_ext;
	logic [IDX_W-1:0]   wr_idx, rd_idx;
	logic [WIDTH_W-1:0] rd_data;

	ppmfd_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign is_tick  = v_s1 && (op_s1 == OP_TICK);
	assign is_edge  = v_s1 && (op_s1 == OP_EDGE);
	assign is_read  = v_s1 && (op_s1 == OP_READ);
	assign has_res  = is_edge || is_read;
	assign advance  = !has_res || !out_valid_q || out_ready;
	assign fire     = has_res && advance;
	assign in_ready = !v_s1 || advance;

	// frame length clamped to 1..MAX_CHANNELS
	always_comb begin
		cnt_ext = 5'(cfg.channel_count);
		if (cnt_ext == 5'd0) begin
			frame_len = 5'd1;
		end else if (cnt_ext > MAX_LEN) begin
			frame_len = MAX_LEN;
		end else begin
			frame_len = cnt_ext;
		end
	end

	assign gap      = tick_q > cfg.sync_threshold;
	assign idx_next = 5'(slot_idx_q) + 5'd1;
	assign wrap     = gap || (idx_next >= frame_len);

	assign wr_ext = 5'(slot_idx_q);
	assign wr_ok  = wr_ext < MAX_LEN;
	assign wr_idx = wr_ext[IDX_W-1:0];

	assign rd_ext  = 5'(rs_s1);
	assign rd_ok   = rd_ext < MAX_LEN;
	assign rd_idx  = rd_ext[IDX_W-1:0];
	assign rd_data = rd_ok ? widths_q[rd_idx] : '0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= operation;
			rs_s1 <= read_slot;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			slot_idx_q <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				widths_q[i] <= '0;
			end
		end else if (advance) begin
			if (is_tick) begin
				tick_q <= tick_q + 16'd1;
			end else if (is_edge) begin
				tick_q <= '0;
				slot_idx_q <= wrap ? 3'd0 : idx_next[2:0];
				if (wr_ok) begin
					widths_q[wr_idx] <= tick_q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			slot_q  <= is_edge ? slot_idx_q : rs_s1;
			width_q <= is_edge ? tick_q : rd_data;
			gap_q   <= is_edge && gap;
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign width     = width_q;
	assign sync_gap  = gap_q;

	`PPMFD_ASSERT_NXT(a_edge_clears_tick, clk, arst_n, is_edge && advance, tick_q == 16'd0)
	`PPMFD_ASSERT_NXT(a_gap_restarts_frame, clk, arst_n, is_edge && advance && gap, slot_idx_q == 3'd0)
	`PPMFD_ASSERT_IMP(a_ready_when_out_free, clk, arst_n, !out_valid_q, in_ready)
	`PPMFD_ASSERT_IMP(a_result_has_source, clk, arst_n, $rose(out_valid_q), $past(v_s1))

endmodule

// ===== tb/ppm_slot_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm frame decoder checker
// follows register writes and input beats, predicts the captured slot widths
// and compares every result beat in order against the oldest prediction
// ----------------------------------------------------------------------------
module ppm_slot_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [ppmfd_pkg::ADDR_W-1:0] paddr,
	input  logic [ppmfd_pkg::DATA_W-1:0] pwdata,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [2:0]                   read_slot,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [2:0]                   slot,
	input  logic [15:0]                  width,
	input  logic                         sync_gap,
	output int                           pending,
	output int                           errors
);

	import ppmfd_pkg::*;

	localparam int SLOTS = 8;

	typedef struct {
		logic [2:0]         slot;
		logic [WIDTH_W-1:0] width;
		logic               sync_gap;
	} capture_t;

	capture_t           pending_captures[$];
	logic [WIDTH_W-1:0] tick_total;
	logic [2:0]         cur_slot;
	logic [WIDTH_W-1:0] slot_store [SLOTS];
	logic [WIDTH_W-1:0] threshold;
	logic [COUNT_W-1:0] chan_count;

	function automatic int frame_slots();
		int n;
		n = int'(chan_count);
		if (n < 1)
			n = 1;
		if (n > SLOTS)
			n = SLOTS;
		return n;
	endfunction

	task automatic decode_beat(input logic [1:0] op, input logic [2:0] rs);
		capture_t c;
		int       s;
		case (op)
			OP_TICK: begin
				tick_total = tick_total + 16'd1;
			end
			OP_EDGE: begin
				s = int'(cur_slot);
				c.slot = cur_slot;
				c.width = tick_total;
				c.sync_gap = tick_total > threshold;
				slot_store[s] = tick_total;
				tick_total = '0;
				if (c.sync_gap || s + 1 >= frame_slots())
					cur_slot = '0;
				else
					cur_slot = 3'(s + 1);
				pending_captures.push_back(c);
			end
			OP_READ: begin
				c.slot = rs;
				c.width = slot_store[rs];
				c.sync_gap = 1'b0;
				pending_captures.push_back(c);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		capture_t want;
		if (!arst_n) begin
			pending_captures.delete();
			tick_total = '0;
			cur_slot = '0;
			for (int i = 0; i < SLOTS; i++)
				slot_store[i] = '0;
			threshold = SYNC_THRESHOLD_RESET;
			chan_count = CHANNEL_COUNT_RESET;
			errors = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_captures.size() == 0) begin
					$error("unexpected result beat: slot %0d width %0d sync_gap %0d",
						slot, width, sync_gap);
					errors = errors + 1;
				end else begin
					want = pending_captures.pop_front();
					if (slot !== want.slot) begin
						$error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
						errors = errors + 1;
					end
					if (width !== want.width) begin
						$error("width mismatch: expected %0d, actual %0d", want.width, width);
						errors = errors + 1;
					end
					if (sync_gap !== want.sync_gap) begin
						$error("sync_gap mismatch: expected %0d, actual %0d",
							want.sync_gap, sync_gap);
						errors = errors + 1;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_sel_t'(paddr[2]))
					REG_SYNC_THRESHOLD: threshold = pwdata[WIDTH_W-1:0];
					REG_CHANNEL_COUNT:  chan_count = pwdata[COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				decode_beat(operation, read_slot);
			pending <= pending_captures.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm frame decoder testbench
// drives tick, edge and read beats with random gaps on both sides, moves the
// sync threshold and channel count between phases, and reports the verdict
// from the checker's error count
// ----------------------------------------------------------------------------
module tb;

	import ppmfd_pkg::*;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         SETTLE_CYCLES  = 4;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [1:0]          operation = OP_TICK;
	logic [2:0]          read_slot = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [2:0]          slot;
	logic [15:0]         width;
	logic                sync_gap;

	int chk_pending;
	int chk_errors;
	int send_idle = 30;
	int recv_idle = 73;
	int beats_sent = 0;
	int quiet = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ppm_frame_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.read_slot (read_slot),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot      (slot),
		.width     (width),
		.sync_gap  (sync_gap)
	);

	ppm_slot_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.read_slot (read_slot),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot      (slot),
		.width     (width),
		.sync_gap  (sync_gap),
		.pending   (chk_pending),
		.errors    (chk_errors)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic send_beat(input logic [1:0] op, input logic [2:0] rs);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		read_slot <= rs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_beat(OP_TICK, 3'($urandom_range(7)));
	endtask

	task automatic send_edge();
		send_beat(OP_EDGE, 3'($urandom_range(7)));
	endtask

	// hold the sender until the checker has seen every predicted beat come out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_sel_t sel, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// sync gap, then a run of channel pulses, sometimes one short or one long
	task automatic send_frame(input int thr, input int chans);
		int n;
		n = chans + $urandom_range(2) - 1;
		if ($urandom_range(99) < 75)
			n = chans;
		send_ticks($urandom_range(thr + 4, thr + 1));
		send_edge();
		repeat (n) begin
			send_ticks($urandom_range(thr, 0));
			send_edge();
			if ($urandom_range(99) < 20)
				send_beat(OP_READ, 3'($urandom_range(7)));
		end
	endtask

	task automatic run_phase(input int sidle, input int ridle, input int items, input bit pause);
		int thr;
		int cnt;
		int chans;
		int start;
		bit paused;
		thr = $urandom_range(12, 2);
		cnt = $urandom_range(15);
		chans = (cnt < 1) ? 1 : (cnt > 8) ? 8 : cnt;
		paused = 1'b0;
		settle();
		write_reg(REG_SYNC_THRESHOLD, {16'($urandom), 16'(thr)});
		write_reg(REG_CHANNEL_COUNT, {28'($urandom), 4'(cnt)});
		send_idle = sidle;
		recv_idle = ridle;
		start = beats_sent;
		while (beats_sent - start < items) begin
			if (pause && !paused && beats_sent - start > items / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 80)
				send_frame(thr, chans);
			else
				repeat ($urandom_range(6, 1))
					send_beat(2'($urandom_range(3)), 3'($urandom_range(7)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset store, zero interval, ignored code, short interval
		send_beat(OP_READ, 3'd0);
		send_edge();
		send_beat(OP_UNUSED, 3'd7);
		send_ticks(3);
		send_edge();
		// longer intervals below the reset threshold
		send_ticks(20);
		send_edge();
		send_ticks(12);
		send_edge();
		send_beat(OP_READ, 3'd7);
		send_beat(OP_READ, 3'd2);

		// zero threshold, channel count zero acts as one
		settle();
		write_reg(REG_SYNC_THRESHOLD, {16'($urandom), 16'd0});
		write_reg(REG_CHANNEL_COUNT, {28'($urandom), 4'd0});
		send_edge();
		send_ticks(1);
		send_edge();
		send_beat(OP_READ, 3'd0);

		// max threshold, then lower the count under the current slot index
		settle();
		write_reg(REG_SYNC_THRESHOLD, {16'($urandom), 16'hFFFF});
		write_reg(REG_CHANNEL_COUNT, {28'($urandom), 4'd8});
		repeat (5) begin
			send_ticks($urandom_range(3, 1));
			send_edge();
		end
		settle();
		write_reg(REG_CHANNEL_COUNT, {28'($urandom), 4'd3});
		send_edge();
		send_edge();
		send_beat(OP_READ, 3'd5);

		// count above the store saturates
		settle();
		write_reg(REG_CHANNEL_COUNT, {28'($urandom), 4'd15});
		write_reg(REG_SYNC_THRESHOLD, {16'($urandom), 16'd8000});
		repeat (9) begin
			send_ticks($urandom_range(2));
			send_edge();
		end
		send_beat(OP_READ, 3'd7);

		run_phase(30, 73, 100, 1'b1);
		run_phase(73, 30, 100, 1'b0);
		run_phase(0, 0, 100, 1'b0);

		settle();
		if (chk_errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
